FILE: hw/rtl/gtcp_pkg.sv
`timescale 1ns / 1ps
package gtcp_pkg;

    localparam logic [1:0] ST_PEND = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_REJ  = 2'd2;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_X  = 8'h78;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_RST   = 2'd1;
    localparam logic [1:0] OP_ACC   = 2'd2;

    // Request passed from the parser to the stick/decode stage.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  status;
        logic [15:0] buttons;
        logic [3:0]  hat;
        logic [31:0] pairs;
    } t_cmd;

endpackage

FILE: hw/rtl/gamepad_text_command_parser_top.sv
`timescale 1ns / 1ps
// Channel   | Direction | Contents
// s_axis    | in        | tdata[7:0] char_byte, tuser func
// m_axis    | out       | tdata status, buttons, hat_dir, left_x, left_y, right_x, right_y
// cfg       | in        | stick_neutral write
// One character is taken every cycle while the queue has room; the parse state advances in one lookup step.
// Each accepted result passes through a two-entry queue and then an output register before it is offered.
// Reset is synchronous; stick neutral returns to 128 and held sticks to neutral.
// Input stalls only when the queue is full; the queue fills while the output is held.
module gamepad_text_command_parser_top
    import gtcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // char_byte
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], buttons[15:2], hat_dir[19:16], left_x[27:20], left_y[35:28],
    // right_x[43:36], right_y[51:44], zero fill to 56
    output logic [55:0] m_axis_tdata
);

    logic [7:0] r_neutral;
    logic       fire, q_ready, q_valid, pop, b_valid;
    t_cmd       f_cmd, q_cmd;
    logic [1:0]  st;
    logic [13:0] btn;
    logic [3:0]  hat;
    logic [15:0] hl, hr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_neutral <= 8'd128;
        else if (i_cfg_we) r_neutral <= i_cfg_wdata;
    end

    assign s_axis_tready = q_ready;

    gtcp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_neutral(r_neutral),
        .i_valid(s_axis_tvalid && q_ready), .i_func(s_axis_tuser),
        .i_char(s_axis_tdata), .o_fire(fire), .o_cmd(f_cmd)
    );

    gtcp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_data(f_cmd),
        .o_ready(q_ready), .o_valid(q_valid), .o_data(q_cmd), .i_pop(pop)
    );

    gtcp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_pop(pop), .o_valid(b_valid), .i_ready(m_axis_tready),
        .o_status(st), .o_buttons(btn), .o_hat(hat), .o_left(hl), .o_right(hr)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {4'd0, hr[15:8], hr[7:0], hl[15:8], hl[7:0], hat, btn, st};

endmodule

FILE: hw/rtl/gtcp_front.sv
`timescale 1ns / 1ps
module gtcp_front
    import gtcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_neutral,
    input  logic       i_valid,
    input  logic       i_func,
    input  logic [7:0] i_char,
    output logic       o_fire,
    output t_cmd       o_cmd
);

    typedef enum logic [9:0] {
        PH_INIT = 10'b0000000001,
        PH_B0   = 10'b0000000010,
        PH_BX   = 10'b0000000100,
        PH_BD   = 10'b0000001000,
        PH_HAT  = 10'b0000010000,
        PH_HATD = 10'b0000100000,
        PH_VAL  = 10'b0001000000,
        PH_CR   = 10'b0010000000,
        PH_ACC  = 10'b0100000000,
        PH_REJ  = 10'b1000000000
    } t_ph;

    typedef enum logic [4:0] {
        V_START = 5'b00001,
        V_ZERO  = 5'b00010,
        V_ZX    = 5'b00100,
        V_ONE   = 5'b01000,
        V_FULL  = 5'b10000
    } t_sub;

    t_ph r_ph, n_ph;
    t_sub r_sub, n_sub;
    logic [2:0] r_cls, n_cls;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_fld, n_fld;
    logic [15:0] r_btn, n_btn;
    logic [3:0] r_hat, n_hat;
    logic [7:0] r_pv [4];
    logic [7:0] n_pv [4];

    logic       hv;
    logic [3:0] h;
    logic       dig;

    always_comb begin
        hv = 1'b1;
        h  = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            h = 4'(i_char - 8'h30);
        end else if (i_char >= 8'h61 && i_char <= 8'h66) begin
            h = 4'(i_char - 8'h57);
        end else begin
            hv = 1'b0;
        end
        dig = hv;
    end

    function automatic logic [2:0] class_of(input logic [3:0] v);
        logic [2:0] c;
        if (v == 4'd3) c = 3'd3;
        else if (v[1:0] == 2'b11) c = 3'd7;
        else if (v[1:0] == 2'b00) c = 3'd0;
        else c = 3'd1;
        return c;
    endfunction

    always_comb begin
        logic odd, first, ending;
        n_ph = r_ph; n_sub = r_sub; n_cls = r_cls; n_cnt = r_cnt;
        n_fld = r_fld; n_btn = r_btn; n_hat = r_hat;
        for (int i = 0; i < 4; i++) n_pv[i] = r_pv[i];
        odd = r_fld[0];
        first = !r_fld[1];
        ending = 1'b0;
        if (i_func) begin
            n_ph = PH_INIT; n_sub = V_START; n_cls = 3'd0; n_cnt = 3'd0;
            n_fld = 2'd0; n_btn = 16'd0; n_hat = 4'd8;
            for (int i = 0; i < 4; i++) n_pv[i] = i_neutral;
        end else begin
            case (r_ph)
                PH_INIT: begin
                    if (!dig) n_ph = PH_REJ;
                    else if (h == 4'd0) n_ph = PH_B0;
                    else begin
                        n_btn = {12'd0, h}; n_cnt = 3'd1;
                        n_cls = class_of(h); n_ph = PH_BD;
                    end
                end
                PH_B0: begin
                    if (i_char == CH_SP) begin
                        n_cls = 3'd0; n_ph = PH_HAT;
                    end else if (i_char == CH_X) begin
                        n_cnt = 3'd0; n_ph = PH_BX;
                    end else n_ph = PH_REJ;
                end
                PH_BX: begin
                    if (!dig) n_ph = PH_REJ;
                    else begin
                        n_btn = {r_btn[11:0], h};
                        n_cnt = r_cnt + 3'd1;
                        if (r_cnt == 3'd3) begin
                            n_cls = class_of(h); n_ph = PH_BD;
                        end
                    end
                end
                PH_BD: begin
                    if (i_char == CH_SP) n_ph = PH_HAT;
                    else if (dig && r_cnt < 3'd4) begin
                        n_btn = {r_btn[11:0], h};
                        n_cnt = r_cnt + 3'd1;
                        n_cls = class_of(h);
                    end else n_ph = PH_REJ;
                end
                PH_HAT: begin
                    if (i_char >= 8'h30 && i_char <= 8'h38) begin
                        n_hat = h; n_ph = PH_HATD;
                    end else n_ph = PH_REJ;
                end
                PH_HATD: begin
                    if (r_cls == 3'd0) begin
                        if (i_char == CH_LF) n_ph = PH_ACC;
                        else if (i_char == CH_CR) n_ph = PH_CR;
                        else n_ph = PH_REJ;
                    end else if (i_char == CH_SP) begin
                        n_fld = 2'd0; n_sub = V_START; n_ph = PH_VAL;
                    end else n_ph = PH_REJ;
                end
                PH_VAL: begin
                    case (r_sub)
                        V_START, V_ZX: begin
                            if (!dig) n_ph = PH_REJ;
                            else if (h == 4'd0) begin
                                n_pv[r_fld] = 8'd0;
                                n_sub = (r_sub == V_ZX) ? V_FULL : V_ZERO;
                            end else begin
                                n_pv[r_fld] = {4'd0, h}; n_sub = V_ONE;
                            end
                        end
                        V_ZERO: begin
                            if (i_char == CH_X) n_sub = V_ZX;
                            else ending = 1'b1;
                        end
                        V_ONE: begin
                            if (dig) begin
                                n_pv[r_fld] = {r_pv[r_fld][3:0], h}; n_sub = V_FULL;
                            end else ending = 1'b1;
                        end
                        V_FULL: ending = 1'b1;
                        default: n_ph = PH_REJ;
                    endcase
                    if (ending) begin
                        if (!odd) begin
                            if (i_char == CH_SP) begin
                                n_fld = r_fld + 2'd1; n_sub = V_START;
                            end else n_ph = PH_REJ;
                        end else if (i_char == CH_SP && first
                                     && (r_cls == 3'd3 || r_cls == 3'd7)) begin
                            n_fld = 2'd2; n_sub = V_START;
                        end else if ((i_char == CH_CR || i_char == CH_LF)
                                     && !(first && r_cls == 3'd7)) begin
                            n_ph = (i_char == CH_LF) ? PH_ACC : PH_CR;
                        end else n_ph = PH_REJ;
                    end
                end
                PH_CR: n_ph = (i_char == CH_LF) ? PH_ACC : PH_REJ;
                default: n_ph = PH_REJ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_INIT; r_sub <= V_START; r_cls <= 3'd0; r_cnt <= 3'd0;
            r_fld <= 2'd0; r_btn <= 16'd0; r_hat <= 4'd8;
            for (int i = 0; i < 4; i++) r_pv[i] <= 8'd128;
        end else if (i_valid) begin
            r_ph <= n_ph; r_sub <= n_sub; r_cls <= n_cls; r_cnt <= n_cnt;
            r_fld <= n_fld; r_btn <= n_btn; r_hat <= n_hat;
            for (int i = 0; i < 4; i++) r_pv[i] <= n_pv[i];
        end
    end

    assign o_fire = i_valid;

    always_comb begin
        o_cmd.buttons = n_btn;
        o_cmd.hat     = (n_hat > 4'd8) ? 4'd8 : n_hat;
        o_cmd.pairs   = {n_pv[3], n_pv[2], n_pv[1], n_pv[0]};
        if (i_func) begin
            o_cmd.op = OP_RST; o_cmd.status = ST_PEND;
        end else if (n_ph == PH_ACC) begin
            o_cmd.op = OP_ACC; o_cmd.status = ST_ACC;
        end else begin
            o_cmd.op = OP_CHAR;
            o_cmd.status = (n_ph == PH_REJ) ? ST_REJ : ST_PEND;
        end
    end

endmodule

FILE: hw/rtl/gtcp_queue.sv
`timescale 1ns / 1ps
module gtcp_queue
    import gtcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

FILE: hw/rtl/gtcp_back.sv
`timescale 1ns / 1ps
module gtcp_back
    import gtcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [13:0] o_buttons,
    output logic [3:0]  o_hat,
    output logic [15:0] o_left,
    output logic [15:0] o_right
);

    logic [15:0] r_held_l, r_held_r, n_held_l, n_held_r;
    logic        r_valid;
    logic        take;

    assign take  = i_valid && (!r_valid || i_ready);
    assign o_pop = take;

    always_comb begin
        n_held_l = r_held_l;
        n_held_r = r_held_r;
        if (i_cmd.op == OP_ACC) begin
            if (i_cmd.buttons[1] && i_cmd.buttons[0]) begin
                n_held_l = i_cmd.pairs[15:0]; n_held_r = i_cmd.pairs[31:16];
            end else if (i_cmd.buttons[1]) n_held_l = i_cmd.pairs[15:0];
            else if (i_cmd.buttons[0]) n_held_r = i_cmd.pairs[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_held_l <= 16'h8080;
            r_held_r <= 16'h8080;
        end else begin
            if (take) begin
                r_valid  <= 1'b1;
                r_held_l <= n_held_l;
                r_held_r <= n_held_r;
            end else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_status <= i_cmd.status;
            if (i_cmd.op == OP_ACC) begin
                o_buttons <= i_cmd.buttons[15:2]; o_hat <= i_cmd.hat;
            end else begin
                o_buttons <= 14'd0; o_hat <= 4'd8;
            end
            o_left  <= n_held_l;
            o_right <= n_held_r;
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/gtcp_checker.sv
`timescale 1ns / 1ps
module gtcp_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("illegal status");

    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd1 |->
        m_axis_tdata[15:2] == 14'd0 && m_axis_tdata[19:16] == 4'd8)
        else $error("buttons or hat set without acceptance");

    a_hat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:16] <= 4'd8)
        else $error("hat out of range");

endmodule

bind gamepad_text_command_parser_top gtcp_props u_gtcp_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
